// ===== hdl/user_buffer_page_access_check_defines.svh =====
// Assertion macros shared by the page access checker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef USER_BUFFER_PAGE_ACCESS_CHECK_DEFINES_SVH
`define USER_BUFFER_PAGE_ACCESS_CHECK_DEFINES_SVH

`ifndef ASSERT_OFF
`define UBPAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UBPAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UBPAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define UBPAC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/ubpac_pkg.sv =====
// Types and constants of the user buffer page access checker.
// Depends on nothing; used by every other file of the block except the macro header.
`timescale 1ns / 1ps

package ubpac_pkg;

    localparam int ADDR_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int ENTRY_W   = 32;
    localparam int DIR_W     = 10;
    localparam int TBL_W     = 10;
    localparam int PAGE_BITS = 12;
    localparam int PN_W      = DIR_W + TBL_W;
    localparam int FLAGS_W   = 4;
    localparam int COW_W     = 5;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DIR_SLOTS    = 1 << DIR_W;
    localparam int PAGE_ENTRIES = 1 << PN_W;

    localparam logic [CMD_W-1:0] CMD_DIR_WR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TBL_WR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COW_POS  = 2'd2;

    localparam logic [ADDR_W-1:0] WIN_LOW_RST  = 32'h0040_0000;
    localparam logic [ADDR_W-1:0] WIN_HIGH_RST = 32'hC000_0000;
    localparam logic [COW_W-1:0]  COW_POS_RST  = 5'd9;

    localparam int FLG_PRESENT  = 0;
    localparam int FLG_WRITABLE = 1;
    localparam int FLG_USER     = 2;
    localparam int FLG_COW      = 3;

    typedef struct packed {
        logic [ADDR_W-1:0] win_low;
        logic [ADDR_W-1:0] win_high;
        logic [COW_W-1:0]  cow_pos;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [DIR_W-1:0]   dir_index;
        logic [TBL_W-1:0]   table_index;
        logic [FLAGS_W-1:0] flags;
        logic               early;
        logic               early_ok;
        logic [PN_W-1:0]    first_pn;
        logic [PN_W-1:0]    last_pn;
        logic               wr_access;
    } t_job;

endpackage

// ===== hdl/ubpac_cmd_if.sv =====
// Command channel of the page access checker: valid, ready and one input beat.
// Depends on ubpac_pkg for the field widths.
`timescale 1ns / 1ps

interface ubpac_cmd_if;
    import ubpac_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [DIR_W-1:0]     dir_index;
    logic [TBL_W-1:0]     table_index;
    logic [ENTRY_W-1:0]   entry_value;
    logic [ADDR_W-1:0]    start_address;
    logic [COUNT_W-1:0]   byte_count;
    logic                 wr_access;

    modport source (
        output valid, command, dir_index, table_index, entry_value,
               start_address, byte_count, wr_access,
        input  ready
    );

    modport sink (
        input  valid, command, dir_index, table_index, entry_value,
               start_address, byte_count, wr_access,
        output ready
    );
endinterface

// ===== hdl/ubpac_res_if.sv =====
// Result channel of the page access checker: valid, ready and the verdict.
// Depends on ubpac_pkg only by convention; it carries one bit of payload.
`timescale 1ns / 1ps

interface ubpac_res_if;
    import ubpac_pkg::*;

    logic valid;
    logic ready;
    logic allowed;

    modport source (
        output valid, allowed,
        input  ready
    );

    modport sink (
        input  valid, allowed,
        output ready
    );
endinterface

// ===== hdl/user_buffer_page_access_check.sv =====
// Top level of the user buffer page access checker: configuration registers,
// front end, job queue and table walker. Depends on ubpac_pkg, both channel
// interfaces, ubpac_front, ubpac_queue and ubpac_back.
`timescale 1ns / 1ps

// After reset the block clears its page tables, one directory and page entry per
// cycle, over all 1,048,576 page entries; no command beat is taken until that pass
// is done, while configuration writes are taken at any time. A command beat then
// passes a front register stage into a job queue of QUEUE_DEPTH entries, so up to
// QUEUE_DEPTH + 1 commands can be taken while the walker is busy. In the walker an
// entry write is applied from the idle state as its job is popped; a check decided
// by its range alone goes straight to the emit state, and a check that walks the
// tables passes a read state and an evaluate state for each page, the read state
// giving a registered read of the directory and page flag memories. The walk stops
// at the first page that fails. The result register lets the walker finish the next
// job while a verdict waits on the result channel.
module user_buffer_page_access_check #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ubpac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ubpac_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    ubpac_cmd_if.sink                          i_cmd,
    ubpac_res_if.source                        o_res
);
    import ubpac_pkg::*;

    t_cfg  r_cfg;
    t_job  front_job;
    t_job  queue_job;
    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    logic  clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_low  <= WIN_LOW_RST;
            r_cfg.win_high <= WIN_HIGH_RST;
            r_cfg.cow_pos  <= COW_POS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIN_LOW:  r_cfg.win_low  <= i_cfg_wdata[ADDR_W-1:0];
                CFG_WIN_HIGH: r_cfg.win_high <= i_cfg_wdata[ADDR_W-1:0];
                CFG_COW_POS:  r_cfg.cow_pos  <= i_cfg_wdata[COW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ubpac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_hold  (clearing),
        .i_cmd   (i_cmd),
        .o_push  (push),
        .o_job   (front_job),
        .i_full  (full)
    );

    ubpac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty)
    );

    ubpac_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (queue_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_res      (o_res)
    );
endmodule

// ===== hdl/ubpac_front.sv =====
// Front end: takes command beats, classifies them and decides range checks
// that need no table walk. Depends on ubpac_pkg and ubpac_cmd_if.
`timescale 1ns / 1ps

module ubpac_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ubpac_pkg::t_cfg  i_cfg,
    input  logic             i_hold,
    ubpac_cmd_if.sink        i_cmd,
    output logic             o_push,
    output ubpac_pkg::t_job  o_job,
    input  logic             i_full
);
    import ubpac_pkg::*;

    logic                 r_valid;
    logic [CMD_W-1:0]     r_command;
    logic [DIR_W-1:0]     r_dir_index;
    logic [TBL_W-1:0]     r_table_index;
    logic [ENTRY_W-1:0]   r_entry_value;
    logic [ADDR_W-1:0]    r_start_address;
    logic [COUNT_W-1:0]   r_byte_count;
    logic                 r_wr_access;

    logic                 known;
    logic                 advance;
    logic [ADDR_W:0]      sum;
    logic [ADDR_W-1:0]    range_end;
    logic                 wraps;
    logic                 empty_range;
    logic                 outside;

    assign known = (r_command == CMD_DIR_WR) || (r_command == CMD_TBL_WR)
                || (r_command == CMD_CHECK);
    assign advance = r_valid && (!known || !i_full);
    assign o_push  = r_valid && known && !i_full;
    assign i_cmd.ready = !i_hold && (!r_valid || advance);

    always_comb begin
        sum         = {1'b0, r_start_address} + {1'b0, r_byte_count};
        range_end   = sum[ADDR_W-1:0];
        wraps       = sum[ADDR_W];
        empty_range = (r_byte_count == '0);
        outside     = (r_start_address < i_cfg.win_low) || (range_end > i_cfg.win_high);

        o_job.command     = r_command;
        o_job.dir_index   = r_dir_index;
        o_job.table_index = r_table_index;
        o_job.wr_access   = r_wr_access;
        if (r_command == CMD_TBL_WR) begin
            o_job.flags = {r_entry_value[i_cfg.cow_pos], r_entry_value[FLG_USER:FLG_PRESENT]};
        end else begin
            o_job.flags = {{(FLAGS_W-1){1'b0}}, r_entry_value[FLG_PRESENT]};
        end
        o_job.early    = wraps || empty_range || outside;
        o_job.early_ok = !wraps && empty_range;
        o_job.first_pn = r_start_address[ADDR_W-1:PAGE_BITS];
        o_job.last_pn  = range_end[ADDR_W-1:PAGE_BITS]
                       - PN_W'(range_end[PAGE_BITS-1:0] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_command       <= i_cmd.command;
            r_dir_index     <= i_cmd.dir_index;
            r_table_index   <= i_cmd.table_index;
            r_entry_value   <= i_cmd.entry_value;
            r_start_address <= i_cmd.start_address;
            r_byte_count    <= i_cmd.byte_count;
            r_wr_access     <= i_cmd.wr_access;
        end
    end
endmodule

// ===== hdl/ubpac_queue.sv =====
// Short job queue between the front end and the table walker.
// Depends on ubpac_pkg for the job type.
`timescale 1ns / 1ps

module ubpac_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ubpac_pkg::t_job  i_job,
    output logic             o_full,
    input  logic             i_pop,
    output ubpac_pkg::t_job  o_job,
    output logic             o_empty
);
    import ubpac_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job               r_slots [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end
endmodule

// ===== hdl/ubpac_back.sv =====
// Back end: holds the directory and page flag memories, applies entry writes,
// walks the pages of a range and drives the result register.
// Depends on ubpac_pkg, ubpac_res_if and the assertion macro header.
`timescale 1ns / 1ps
`include "user_buffer_page_access_check_defines.svh"

module ubpac_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  ubpac_pkg::t_job  i_job,
    output logic             o_pop,
    output logic             o_clearing,
    ubpac_res_if.source      o_res
);
    import ubpac_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [FLAGS_W-1:0] flg_mem [PAGE_ENTRIES];
    logic               dir_mem [DIR_SLOTS];

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [PN_W-1:0]     r_clr_addr;
    logic [PN_W-1:0]     n_clr_addr;
    logic [PN_W-1:0]     r_pn;
    logic [PN_W-1:0]     n_pn;
    logic [PN_W-1:0]     r_last;
    logic [PN_W-1:0]     n_last;
    logic                r_wr;
    logic                n_wr;
    logic                r_res;
    logic                n_res;
    logic                r_out_valid;
    logic                r_out_allowed;
    logic [FLAGS_W-1:0]  r_flg_q;
    logic                r_dir_q;

    logic                flg_we;
    logic [PN_W-1:0]     flg_waddr;
    logic [FLAGS_W-1:0]  flg_wdata;
    logic                dir_we;
    logic [DIR_W-1:0]    dir_waddr;
    logic                dir_wdata;
    logic                out_free;
    logic                emit;
    logic                page_ok;

    assign out_free   = !r_out_valid || o_res.ready;
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_res.valid   = r_out_valid;
    assign o_res.allowed = r_out_allowed;

    assign page_ok = r_dir_q && r_flg_q[FLG_PRESENT] && r_flg_q[FLG_USER]
                  && (!r_wr || r_flg_q[FLG_WRITABLE] || r_flg_q[FLG_COW]);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_pn       = r_pn;
        n_last     = r_last;
        n_wr       = r_wr;
        n_res      = r_res;
        o_pop      = 1'b0;
        emit       = 1'b0;
        flg_we     = 1'b0;
        flg_waddr  = {i_job.dir_index, i_job.table_index};
        flg_wdata  = i_job.flags;
        dir_we     = 1'b0;
        dir_waddr  = i_job.dir_index;
        dir_wdata  = i_job.flags[FLG_PRESENT];
        unique case (r_state)
            ST_CLEAR: begin
                flg_we     = 1'b1;
                flg_waddr  = r_clr_addr;
                flg_wdata  = '0;
                dir_we     = 1'b1;
                dir_waddr  = r_clr_addr[DIR_W-1:0];
                dir_wdata  = 1'b0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_job.command)
                        CMD_DIR_WR: begin
                            dir_we = 1'b1;
                        end
                        CMD_TBL_WR: begin
                            flg_we = 1'b1;
                        end
                        CMD_CHECK: begin
                            if (i_job.early) begin
                                n_res   = i_job.early_ok;
                                n_state = ST_EMIT;
                            end else begin
                                n_pn    = i_job.first_pn;
                                n_last  = i_job.last_pn;
                                n_wr    = i_job.wr_access;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!page_ok || (r_pn == r_last)) begin
                    n_res   = page_ok;
                    n_state = ST_EMIT;
                end else begin
                    n_pn    = r_pn + 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pn   <= n_pn;
        r_last <= n_last;
        r_wr   <= n_wr;
        r_res  <= n_res;
        if (emit) begin
            r_out_allowed <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (flg_we) begin
            flg_mem[flg_waddr] <= flg_wdata;
        end
        r_flg_q <= flg_mem[r_pn];
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        r_dir_q <= dir_mem[r_pn[PN_W-1:TBL_W]];
    end

    `UBPAC_ASSERT_ALWAYS(a_reset_starts_clear, i_clk, !i_rst_n |=> (r_state == ST_CLEAR), "reset did not start the clearing pass")
    `UBPAC_ASSERT(a_no_pop_while_clear, i_clk, i_rst_n, (r_state == ST_CLEAR) |-> !o_pop, "job taken during the clearing pass")
    `UBPAC_ASSERT(a_walk_in_bounds, i_clk, i_rst_n, (r_state == ST_EVAL) |-> (r_pn <= r_last), "page walk ran past the last page")
    `UBPAC_ASSERT(a_emit_loads_result, i_clk, i_rst_n, (r_state == ST_EMIT) && out_free |=> r_out_valid && (r_state == ST_IDLE), "verdict not loaded into the result register")
endmodule
